[src/pom_pkg.sv]
// Shared constants for the polyphonic oscillator mixer.
// Command, waveform and register codes, keymap, octave pitch and sine tables.
// No dependencies.
package pom_pkg;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_OCTAVE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SHAPE_SIN  = 2'd0,
    SHAPE_SQR  = 2'd1,
    SHAPE_RAMP = 2'd2,
    SHAPE_TRI  = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    REG_WAVE_SHAPE   = 2'd0,
    REG_ATTACK_STEP  = 2'd1,
    REG_RELEASE_STEP = 2'd2
  } reg_index_t;

  localparam int MAP_KEYS       = 26;
  localparam int REF_LOW_VOICE  = 9;
  localparam int REF_HIGH_VOICE = 15;
  localparam int LOWEST_NOTE    = 21;
  localparam int OCTAVE_NOTES   = 12;

  localparam logic [16:0] ENV_FULL      = 17'd65536;
  localparam logic [16:0] STEP_DEFAULT  = 17'd1486;
  localparam logic signed [15:0] WAVE_MAX = 16'sd32767;

  localparam logic [0:MAP_KEYS-1][6:0] DEFAULT_MAP = '{
    7'd62, 7'd0,  7'd66, 7'd65, 7'd0,  7'd67, 7'd0,  7'd0,  7'd70,
    7'd69, 7'd71, 7'd72, 7'd70, 7'd68, 7'd0,  7'd73, 7'd61, 7'd66,
    7'd64, 7'd68, 7'd68, 7'd68, 7'd63, 7'd0,  7'd0,  7'd63
  };

  // Q16.16 Hz of notes 60..71
  localparam logic [0:OCTAVE_NOTES-1][31:0] OCTAVE_HZ = '{
    32'd17145892, 32'd18165441, 32'd19245614, 32'd20390018,
    32'd21602472, 32'd22887021, 32'd24247955, 32'd25689813,
    32'd27217409, 32'd28835840, 32'd30550508, 32'd32367136
  };

  // quarter-wave sine polynomial, Q30, highest order first
  localparam logic [31:0] SIN_C0 = 32'd172273;
  localparam logic [31:0] SIN_C1 = 32'd5026995;
  localparam logic [31:0] SIN_C2 = 32'd85569306;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C4 = 32'd1686629713;

endpackage

[src/polyphonic_oscillator_mixer_unit.sv]
// Polyphonic oscillator mixer top level: voice bank, envelope, waveform and mix sequencer.
// Depends on pom_pkg and pom_div.
//
// Usage:
//  s_* carries commands: tdata = {shift_up, key_index, cmd}. A key press or
//  release updates the held flag in the transfer cycle and gives no result.
//  An octave shift gives one status result (tuser 1) via out_pend and the output register.
//  A sample tick walks every voice through one shared 32x32 multiplier: an
//  unmapped or silent voice passes S_ENV only, square/saw/triangle S_ENV, S_MAC
//  and S_ACC, sine also S_SQ, S_H0 to S_H4, S_SY and S_SR. The mean then takes
//  S_FIN, the restoring divider in S_DIV (skipped when no voice sounds) and the
//  result hand-off, which waits in out_pend until the output register is free.
//  s_tready is high only between items. m_* carries results: tuser = kind,
//  tdata = {2'b0, shift_done, active_voices, right_sample, left_sample}.
//  One output register holds a result while the receiver stalls; the next
//  command is accepted meanwhile, and a later result waits for that slot.
//  cfg_* writes wave_shape (0), attack_step (1), release_step (2); always ready.
//  Reset clears held flags, phases and envelopes, loads the default keymap
//  and the register defaults. No clearing pass.
module polyphonic_oscillator_mixer_unit #(
  parameter int N_VOICES       = 26,
  parameter int NOTE_LIMIT     = 108,
  parameter int PHASE_BITS     = 32,
  parameter int SAMPLE_RATE_HZ = 44100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // cmd[1:0], key_index[6:2], shift_up[7]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // left_sample[15:0], right_sample[31:16],
                                 // active_voices[36:32], shift_done[37], zero[39:38]
  output logic [0:0]  m_tuser,   // kind[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int VIDX_W = (N_VOICES > 1) ? $clog2(N_VOICES) : 1;
  localparam int CNT_W  = $clog2(N_VOICES + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int MAG_W  = SUM_W - 1;

  typedef logic [127:0][PHASE_BITS-1:0] step_rom_t;

  function automatic step_rom_t build_steps();
    step_rom_t   rom;
    logic [63:0] base;
    logic [63:0] step;
    for (int k = 0; k < 128; k++) begin
      base = (64'(pom_pkg::OCTAVE_HZ[k % 12]) << PHASE_BITS) / 64'(SAMPLE_RATE_HZ);
      step = ((base << (k / 12)) + 64'(1 << 20)) >> 21;
      rom[k] = (k == 0) ? '0 : step[PHASE_BITS-1:0];
    end
    return rom;
  endfunction

  localparam step_rom_t STEP_ROM = build_steps();

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_ENV  = 14'b00000000000010,
    S_SQ   = 14'b00000000000100,
    S_H0   = 14'b00000000001000,
    S_H1   = 14'b00000000010000,
    S_H2   = 14'b00000000100000,
    S_H3   = 14'b00000001000000,
    S_H4   = 14'b00000010000000,
    S_SY   = 14'b00000100000000,
    S_SR   = 14'b00001000000000,
    S_MAC  = 14'b00010000000000,
    S_ACC  = 14'b00100000000000,
    S_FIN  = 14'b01000000000000,
    S_DIV  = 14'b10000000000000
  } state_t;

  // S_OUT shares the one-hot space through a flag of its own
  state_t state;
  logic   out_pend;

  logic [1:0]  wave_shape;
  logic [16:0] attack_step;
  logic [16:0] release_step;

  logic                  key_held [N_VOICES];
  logic [6:0]            note     [N_VOICES];
  logic [PHASE_BITS-1:0] phase    [N_VOICES];
  logic [16:0]           env      [N_VOICES];

  logic [VIDX_W-1:0]        idx;
  logic [CNT_W-1:0]         count;
  logic signed [SUM_W-1:0]  sum;
  logic [63:0]              prod;
  logic [31:0]              x_r;
  logic [31:0]              x2_r;
  logic                     sneg_r;
  logic signed [15:0]       w_r;
  logic                     mneg_r;
  logic [16:0]              e_r;
  logic                     res_kind;
  logic                     res_done;
  logic signed [15:0]       res_left;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] t_next;

  logic [1:0]  in_cmd;
  logic [4:0]  in_key;
  logic        in_up;
  logic        accept;
  logic [6:0]  note_lo;
  logic [6:0]  note_hi;
  logic        shift_ok;

  logic [6:0]            cur_note;
  logic [16:0]           cur_env;
  logic [16:0]           env_new;
  logic [17:0]           env_up;
  logic [31:0]           p32;
  logic [31:0]           sin_x;
  logic signed [15:0]    w_direct;
  logic signed [17:0]    tri_s;
  logic [34:0]           sin_y;
  logic [14:0]           sin_mag;
  logic [15:0]           w_abs;
  logic                  last_voice;

  logic             div_start;
  logic             div_done;
  logic [MAG_W-1:0] div_num;
  logic [MAG_W-1:0] div_quo;
  logic [MAG_W:0]   mean_rnd;
  logic [15:0]      mean_mag;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && !out_pend;
  assign accept    = s_tvalid && s_tready;
  assign in_cmd    = s_tdata[1:0];
  assign in_key    = s_tdata[6:2];
  assign in_up     = s_tdata[7];

  if (N_VOICES > pom_pkg::REF_LOW_VOICE) begin : g_lo
    assign note_lo = note[pom_pkg::REF_LOW_VOICE];
  end else begin : g_lo_none
    assign note_lo = '0;
  end
  if (N_VOICES > pom_pkg::REF_HIGH_VOICE) begin : g_hi
    assign note_hi = note[pom_pkg::REF_HIGH_VOICE];
  end else begin : g_hi_none
    assign note_hi = '0;
  end

  assign shift_ok = in_up ? (({2'b0, note_hi} + 9'd12) < 9'(NOTE_LIMIT))
                          : (note_lo >= 7'(pom_pkg::LOWEST_NOTE + 12));

  assign cur_note   = note[idx];
  assign cur_env    = env[idx];
  assign last_voice = (idx == VIDX_W'(N_VOICES - 1));
  assign env_up     = {1'b0, cur_env} + {1'b0, attack_step};
  assign p32        = 32'(phase[idx]) << (32 - PHASE_BITS);
  assign sin_x      = p32[30] ? (32'h4000_0000 - {2'b0, p32[29:0]}) : {2'b0, p32[29:0]};
  assign sin_y      = 35'((prod + 64'(1 << 29)) >> 30);
  assign sin_mag    = (sin_y > 35'd32767) ? 15'd32767 : sin_y[14:0];
  assign w_abs      = w_r[15] ? 16'(-w_r) : 16'(w_r);

  always_comb begin
    if (key_held[idx]) begin
      env_new = (env_up > {1'b0, pom_pkg::ENV_FULL}) ? pom_pkg::ENV_FULL : env_up[16:0];
    end else begin
      env_new = (cur_env > release_step) ? (cur_env - release_step) : 17'd0;
    end
  end

  always_comb begin
    tri_s = p32[31] ? (18'sd98304 - $signed({1'b0, p32[31:15]}))
                    : ($signed({1'b0, p32[31:15]}) - 18'sd32768);
    case (wave_shape)
      pom_pkg::SHAPE_SQR: w_direct = p32[31] ? -pom_pkg::WAVE_MAX : pom_pkg::WAVE_MAX;
      pom_pkg::SHAPE_RAMP: begin
        w_direct = $signed({~p32[31], p32[30:16]});
        if (w_direct == -16'sd32768) w_direct = -pom_pkg::WAVE_MAX;
      end
      default: begin
        if (tri_s > 18'sd32767) w_direct = pom_pkg::WAVE_MAX;
        else if (tri_s < -18'sd32767) w_direct = -pom_pkg::WAVE_MAX;
        else w_direct = tri_s[15:0];
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_H1:    t_next = pom_pkg::SIN_C1 - prod[61:30];
      S_H2:    t_next = pom_pkg::SIN_C2 - prod[61:30];
      S_H3:    t_next = pom_pkg::SIN_C3 - prod[61:30];
      S_H4:    t_next = pom_pkg::SIN_C4 - prod[61:30];
      default: t_next = prod[61:30];
    endcase
  end

  always_comb begin
    mul_a = x_r;
    mul_b = x_r;
    unique case (state)
      S_H0: begin
        mul_a = pom_pkg::SIN_C0;
        mul_b = prod[61:30];
      end
      S_H1, S_H2, S_H3: begin
        mul_a = t_next;
        mul_b = x2_r;
      end
      S_H4: begin
        mul_a = t_next;
        mul_b = x_r;
      end
      S_SY: begin
        mul_a = prod[61:30];
        mul_b = 32'd32767;
      end
      S_MAC: begin
        mul_a = 32'(e_r);
        mul_b = 32'(w_abs);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  assign div_num   = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
  assign div_start = (state == S_FIN) && (count != '0);
  assign mean_rnd  = ({1'b0, div_quo} + (MAG_W+1)'(32768)) >> 16;
  assign mean_mag  = (mean_rnd > (MAG_W+1)'(32767)) ? 16'd32767 : mean_rnd[15:0];

  pom_div #(
    .NUM_W (MAG_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (count),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_pend     <= 1'b0;
      m_tvalid     <= 1'b0;
      wave_shape   <= pom_pkg::SHAPE_SIN;
      attack_step  <= pom_pkg::STEP_DEFAULT;
      release_step <= pom_pkg::STEP_DEFAULT;
      idx          <= '0;
      count        <= '0;
      for (int v = 0; v < N_VOICES; v++) begin
        key_held[v] <= 1'b0;
        note[v]     <= (v < pom_pkg::MAP_KEYS) ? pom_pkg::DEFAULT_MAP[v % pom_pkg::MAP_KEYS]
                                               : 7'd0;
        phase[v]    <= '0;
        env[v]      <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pom_pkg::REG_WAVE_SHAPE:   wave_shape   <= cfg_data[1:0];
          pom_pkg::REG_ATTACK_STEP:  attack_step  <= cfg_data;
          pom_pkg::REG_RELEASE_STEP: release_step <= cfg_data;
          default: ;
        endcase
      end

      // hand the finished result to the output register once it is free
      if (out_pend && (!m_tvalid || m_tready)) begin
        out_pend <= 1'b0;
        m_tvalid <= 1'b1;
        m_tuser  <= res_kind;
        m_tdata  <= {2'b0, res_done, res_kind ? 5'd0 : 5'(count),
                     16'(-res_left), res_left};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_cmd) inside
              pom_pkg::CMD_PRESS, pom_pkg::CMD_RELEASE: begin
                for (int v = 0; v < N_VOICES; v++) begin
                  if (32'(in_key) == v) key_held[v] <= (in_cmd == pom_pkg::CMD_PRESS);
                end
              end
              pom_pkg::CMD_OCTAVE: begin
                if (shift_ok) begin
                  for (int v = 0; v < N_VOICES; v++) begin
                    if (note[v] != 7'd0) note[v] <= note[v] + (in_up ? 7'd12 : 7'd116);
                  end
                end
                res_kind <= 1'b1;
                res_done <= shift_ok;
                res_left <= '0;
                out_pend <= 1'b1;
              end
              default: begin
                res_kind <= 1'b0;
                res_done <= 1'b0;
                sum      <= '0;
                count    <= '0;
                idx      <= '0;
                state    <= S_ENV;
              end
            endcase
          end
        end
        S_ENV: begin
          e_r    <= env_new;
          x_r    <= sin_x;
          sneg_r <= p32[31];
          w_r    <= w_direct;
          if (cur_note != 7'd0) env[idx] <= env_new;
          if (cur_note == 7'd0 || env_new == 17'd0) begin
            if (last_voice) state <= S_FIN;
            else idx <= idx + VIDX_W'(1);
          end else if (wave_shape == pom_pkg::SHAPE_SIN) begin
            state <= S_SQ;
          end else begin
            state <= S_MAC;
          end
        end
        S_SQ: state <= S_H0;
        S_H0: begin
          x2_r  <= prod[61:30];
          state <= S_H1;
        end
        S_H1: state <= S_H2;
        S_H2: state <= S_H3;
        S_H3: state <= S_H4;
        S_H4: state <= S_SY;
        S_SY: state <= S_SR;
        S_SR: begin
          w_r   <= sneg_r ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
          state <= S_MAC;
        end
        S_MAC: begin
          mneg_r <= w_r[15];
          state  <= S_ACC;
        end
        S_ACC: begin
          sum        <= mneg_r ? (sum - $signed(SUM_W'(prod))) : (sum + $signed(SUM_W'(prod)));
          count      <= count + CNT_W'(1);
          phase[idx] <= phase[idx] + STEP_ROM[cur_note];
          if (last_voice) state <= S_FIN;
          else begin
            idx   <= idx + VIDX_W'(1);
            state <= S_ENV;
          end
        end
        S_FIN: begin
          if (count == '0) begin
            res_left <= '0;
            out_pend <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_left <= sum[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
            out_pend <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[36:0] == 37'd0)
    else $error("octave status carries sample data");

  a_right_neg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:16] == 16'(-m_tdata[15:0]) && !m_tdata[37])
    else $error("right sample is not the negated left sample");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(N_VOICES))
    else $error("active voice count exceeds voice bank");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the mean step");

  a_env_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> e_r <= pom_pkg::ENV_FULL && e_r != 17'd0)
    else $error("envelope out of range at accumulate");
`endif

endmodule

[src/pom_div.sv]
// Restoring divider, one quotient bit per cycle.
// Unsigned numerator over unsigned denominator; no package dependency.
module pom_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        rem <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
